@@ hw/rtl/stwrm_pkg.sv @@
`timescale 1ns / 1ps

package stwrm_pkg;

    // One tick of the pin sequencer
    typedef struct packed {
        logic       action;
        logic [7:0] command;
        logic       data_in;
    } in_t;

    // Pin levels and transaction status after the tick
    typedef struct packed {
        logic        clock_out;
        logic        data_release;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [15:0] raw_value;
    } out_t;

    localparam int CFG_W   = 32;
    localparam int PHASE_W = 10;
    localparam int WAIT_W  = 32;

    // Register indexes on the write port
    localparam logic REG_PHASE_TICKS = 1'b0;
    localparam logic REG_WAIT_LIMIT  = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 10'd100;
    localparam logic [WAIT_W-1:0]  WAIT_LIMIT_RST  = 32'd100000000;

    // Pin steps that the ack release check lasts
    localparam logic [WAIT_W-1:0] ACK_REL_STEPS = 32'd10;
    localparam logic [2:0]        LAST_BIT      = 3'd7;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_ACK    = 2'd1;
    localparam logic [1:0] STATUS_ACK_STUCK = 2'd2;
    localparam logic [1:0] STATUS_TIMEOUT   = 2'd3;

endpackage

@@ hw/rtl/stwrm_seq.sv @@
`timescale 1ns / 1ps

module stwrm_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step_en,
    input  stwrm_pkg::in_t               item,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [stwrm_pkg::CFG_W-1:0]  cfg_data,
    output stwrm_pkg::out_t              res
);

    typedef enum logic [4:0] {
        S_IDLE, S_ST0, S_ST1, S_ST2, S_ST3, S_ST4, S_CMDH, S_CMDL, S_ACKH, S_ACKREL,
        S_WAIT, S_A_H1, S_A_H2, S_A_L, S_MACKH, S_MACKL, S_B_H1, S_B_H2, S_B_L, S_CRC
    } step_t;

    // {clock level, data release} for each step
    function automatic logic [1:0] pin_levels(input step_t s);
        logic [1:0] levels;
        begin
            unique case (s)
                S_ST1:                        levels = 2'b10;
                S_ST2:                        levels = 2'b00;
                S_ST3, S_CMDH, S_ACKH,
                S_A_H1, S_A_H2, S_B_H1,
                S_B_H2, S_CRC:                levels = 2'b11;
                S_MACKH:                      levels = 2'b10;
                S_MACKL:                      levels = 2'b00;
                default:                      levels = 2'b01;
            endcase
            return levels;
        end
    endfunction

    logic [stwrm_pkg::PHASE_W-1:0] phase_ticks_reg;
    logic [stwrm_pkg::WAIT_W-1:0]  wait_limit_reg;

    step_t                         step_reg, step_next;
    logic [2:0]                    bit_count_reg, bit_count_next;
    logic [stwrm_pkg::PHASE_W-1:0] phase_count_reg, phase_count_next;
    logic [stwrm_pkg::WAIT_W-1:0]  wait_count_reg, wait_count_next;
    logic [15:0]                   shift_data_reg, shift_data_next;
    logic [7:0]                    command_hold_reg, command_hold_next;
    logic                          clock_level_reg, clock_level_next;
    logic                          line_released_reg, line_released_next;

    logic [stwrm_pkg::PHASE_W-1:0] plen;
    logic [stwrm_pkg::WAIT_W-1:0]  wlim;
    logic [stwrm_pkg::PHASE_W-1:0] phase_inc;
    logic [stwrm_pkg::WAIT_W-1:0]  wait_inc;
    logic                          go;
    step_t                         target;
    logic                          fin;
    logic [1:0]                    fin_code;
    logic [1:0]                    lv;

    assign plen      = (phase_ticks_reg == '0) ? stwrm_pkg::PHASE_W'(1) : phase_ticks_reg;
    assign wlim      = (wait_limit_reg == '0) ? stwrm_pkg::WAIT_W'(1) : wait_limit_reg;
    assign phase_inc = phase_count_reg + stwrm_pkg::PHASE_W'(1);
    assign wait_inc  = wait_count_reg + stwrm_pkg::WAIT_W'(1);

    always_comb
    begin
        step_next          = step_reg;
        bit_count_next     = bit_count_reg;
        phase_count_next   = phase_count_reg;
        wait_count_next    = wait_count_reg;
        shift_data_next    = shift_data_reg;
        command_hold_next  = command_hold_reg;
        clock_level_next   = clock_level_reg;
        line_released_next = line_released_reg;
        go       = 1'b0;
        target   = S_IDLE;
        fin      = 1'b0;
        fin_code = stwrm_pkg::STATUS_OK;
        lv       = 2'b01;

        if (step_en)
        begin
            unique case (step_reg)
                S_IDLE:
                begin
                    if (item.action)
                    begin
                        command_hold_next = item.command;
                        bit_count_next    = '0;
                        wait_count_next   = '0;
                        shift_data_next   = '0;
                        go                = 1'b1;
                        target            = S_ST0;
                    end
                end
                S_WAIT:
                begin
                    if (!item.data_in)
                    begin
                        bit_count_next = '0;
                        go             = 1'b1;
                        target         = S_A_H1;
                    end
                    else
                    begin
                        wait_count_next = wait_inc;
                        if (wait_inc >= wlim)
                        begin
                            fin      = 1'b1;
                            fin_code = stwrm_pkg::STATUS_TIMEOUT;
                        end
                    end
                end
                default:
                begin
                    phase_count_next = phase_inc;
                    if (phase_inc >= plen)
                    begin
                        unique case (step_reg) inside
                            S_ST0, S_ST1, S_ST2, S_ST3, S_A_H2, S_B_H2, S_MACKH:
                            begin
                                go     = 1'b1;
                                target = step_t'(step_reg + 5'd1);
                            end
                            S_ST4:
                            begin
                                bit_count_next = '0;
                                go             = 1'b1;
                                target         = S_CMDH;
                            end
                            S_CMDH:
                            begin
                                go     = 1'b1;
                                target = S_CMDL;
                            end
                            S_CMDL:
                            begin
                                go = 1'b1;
                                if (bit_count_reg >= stwrm_pkg::LAST_BIT)
                                begin
                                    bit_count_next = '0;
                                    target         = S_ACKH;
                                end
                                else
                                begin
                                    bit_count_next = bit_count_reg + 3'd1;
                                    target         = S_CMDH;
                                end
                            end
                            S_ACKH:
                            begin
                                if (item.data_in)
                                begin
                                    fin      = 1'b1;
                                    fin_code = stwrm_pkg::STATUS_NO_ACK;
                                end
                                else
                                begin
                                    wait_count_next = '0;
                                    go              = 1'b1;
                                    target          = S_ACKREL;
                                end
                            end
                            S_ACKREL:
                            begin
                                wait_count_next = wait_inc;
                                if (wait_inc < stwrm_pkg::ACK_REL_STEPS)
                                    phase_count_next = '0;
                                else if (!item.data_in)
                                begin
                                    fin      = 1'b1;
                                    fin_code = stwrm_pkg::STATUS_ACK_STUCK;
                                end
                                else
                                begin
                                    wait_count_next = '0;
                                    go              = 1'b1;
                                    target          = S_WAIT;
                                end
                            end
                            S_A_H1, S_B_H1:
                            begin
                                shift_data_next = {shift_data_reg[14:0], item.data_in};
                                go              = 1'b1;
                                target          = step_t'(step_reg + 5'd1);
                            end
                            S_A_L, S_B_L:
                            begin
                                go = 1'b1;
                                if (bit_count_reg >= stwrm_pkg::LAST_BIT)
                                begin
                                    bit_count_next = '0;
                                    target         = (step_reg == S_A_L) ? S_MACKH : S_CRC;
                                end
                                else
                                begin
                                    bit_count_next = bit_count_reg + 3'd1;
                                    target         = step_t'(step_reg - 5'd2);
                                end
                            end
                            S_MACKL:
                            begin
                                bit_count_next = '0;
                                go             = 1'b1;
                                target         = S_B_H1;
                            end
                            S_CRC:
                            begin
                                fin      = 1'b1;
                                fin_code = stwrm_pkg::STATUS_OK;
                            end
                            default:
                            begin
                                go     = 1'b1;
                                target = S_IDLE;
                            end
                        endcase
                    end
                end
            endcase
        end

        // End of transaction: drop back to idle, clock low, line released
        if (fin)
        begin
            go     = 1'b1;
            target = S_IDLE;
        end

        if (go)
        begin
            lv                 = pin_levels(target);
            step_next          = target;
            phase_count_next   = '0;
            clock_level_next   = lv[1];
            line_released_next = lv[0];
            if (target == S_CMDH || target == S_CMDL)
                line_released_next = command_hold_next[stwrm_pkg::LAST_BIT - bit_count_next];
        end
    end

    always_comb
    begin
        res.clock_out    = clock_level_next;
        res.data_release = line_released_next;
        res.busy_res     = (step_next != S_IDLE);
        res.done_res     = fin;
        res.status       = fin ? fin_code : stwrm_pkg::STATUS_OK;
        res.raw_value    = (fin && fin_code == stwrm_pkg::STATUS_OK) ? shift_data_next : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= stwrm_pkg::PHASE_TICKS_RST;
            wait_limit_reg  <= stwrm_pkg::WAIT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                stwrm_pkg::REG_PHASE_TICKS:
                    phase_ticks_reg <= cfg_data[stwrm_pkg::PHASE_W-1:0];
                stwrm_pkg::REG_WAIT_LIMIT:
                    wait_limit_reg  <= cfg_data[stwrm_pkg::WAIT_W-1:0];
                default:
                    phase_ticks_reg <= phase_ticks_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg          <= S_IDLE;
            bit_count_reg     <= '0;
            phase_count_reg   <= '0;
            wait_count_reg    <= '0;
            shift_data_reg    <= '0;
            command_hold_reg  <= '0;
            clock_level_reg   <= 1'b0;
            line_released_reg <= 1'b1;
        end
        else if (step_en)
        begin
            step_reg          <= step_next;
            bit_count_reg     <= bit_count_next;
            phase_count_reg   <= phase_count_next;
            wait_count_reg    <= wait_count_next;
            shift_data_reg    <= shift_data_next;
            command_hold_reg  <= command_hold_next;
            clock_level_reg   <= clock_level_next;
            line_released_reg <= line_released_next;
        end
    end

endmodule

@@ hw/rtl/stwrm_out.sv @@
`timescale 1ns / 1ps

module stwrm_out (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load_valid,
    input  stwrm_pkg::out_t load_data,
    output logic            load_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output stwrm_pkg::out_t out_data
);

    logic            valid_reg;
    stwrm_pkg::out_t data_reg;

    // Hold while the result waits; refill in the cycle it drains
    assign load_stall = valid_reg && out_stall;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!load_stall)
            valid_reg <= load_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!load_stall && load_valid)
            data_reg <= load_data;
    end

endmodule

@@ hw/rtl/sensor_two_wire_read_master.sv @@
`timescale 1ns / 1ps

// The result of an item is loaded into the output register as the item is accepted.
// Throughput: one item per cycle; the sequencer step and the result register both update
// in the accept cycle, and a waiting result stalls input only while out_stall is high.
// Reset: sequencer idle, clock line low, data line released, output register empty,
// phase_ticks 100 and wait_limit 100000000.
module sensor_two_wire_read_master (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  stwrm_pkg::in_t              in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output stwrm_pkg::out_t             out_data,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [stwrm_pkg::CFG_W-1:0] cfg_data
);

    logic            accept;
    stwrm_pkg::out_t res;

    assign accept = in_valid && !in_stall;

    stwrm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (accept),
        .item      (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (res)
    );

    stwrm_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (in_valid),
        .load_data  (res),
        .load_stall (in_stall),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
